FILE: sv/hc_pkg.sv
// shared types, constants and helper functions for the 2x2 hill cipher unit
package hc_pkg;

  localparam logic [7:0] CHAR_LC_A  = 8'd97;
  localparam logic [7:0] CHAR_LC_Z  = 8'd122;
  localparam logic [7:0] CHAR_UC_A  = 8'd65;
  localparam logic [7:0] CHAR_UC_Z  = 8'd90;
  localparam logic [6:0] OUT_BASE   = 7'd65;
  localparam logic [4:0] PAD_LETTER = 5'd23;
  localparam logic [4:0] ALPHA_N    = 5'd26;
  localparam logic [10:0] DET_BIAS  = 11'd676;
  localparam logic [2:0] KEY_LAT    = 3'd4;

  typedef enum logic [2:0] {
    CFG_KEY_A = 3'd0,
    CFG_KEY_B = 3'd1,
    CFG_KEY_C = 3'd2,
    CFG_KEY_D = 3'd3,
    CFG_MODE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAIR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_end;
  } hc_in_t;

  typedef struct packed {
    logic [6:0] out_letter;
    logic       has_letter;
    logic       last_of_run;
    logic       end_marker;
    logic       key_error;
  } hc_out_t;

  // active matrix and whether it may be used
  typedef struct packed {
    logic [4:0] m0;
    logic [4:0] m1;
    logic [4:0] m2;
    logic [4:0] m3;
    logic       ok;
  } key_t;

  // work item between the pairing stage and the output stage
  typedef struct packed {
    kind_t       kind;
    logic [10:0] sum1;
    logic [10:0] sum2;
    logic        text_end;
  } pair_item_t;

  // values below 2048: quotient by reciprocal 2521/65536 is exact here
  function automatic logic [4:0] mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [11:0] qm;
    logic [10:0] r;
    prod = x * 12'd2521;
    q    = prod[22:16];
    qm   = q * ALPHA_N;
    r    = x - qm[10:0];
    return r[4:0];
  endfunction

  function automatic logic [4:0] red26(input logic [4:0] x);
    return (x >= ALPHA_N) ? x - ALPHA_N : x;
  endfunction

  // reciprocal mod 26, zero where none exists
  function automatic logic [4:0] recip26(input logic [4:0] d);
    logic [4:0] r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/hc_key_unit.sv
// configuration registers and the pipelined derivation of the active key matrix
module hc_key_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_fire,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_data,
  output hc_pkg::key_t     key,
  output logic             key_ready
);
  import hc_pkg::*;

  logic [4:0] key_a_r, key_b_r, key_c_r, key_d_r;
  logic       mode_r;
  logic [2:0] settle_r;

  // stage 1: reduced entries and determinant products
  logic [4:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [9:0] s1_ad_r, s1_bc_r;
  logic       s1_mode_r;
  // stage 2: reciprocal of determinant
  logic [4:0] s2_a_r, s2_b_r, s2_c_r, s2_d_r, s2_r_r;
  logic       s2_mode_r;
  // stage 3: adjugate times reciprocal, unreduced
  logic [4:0] s3_a_r, s3_b_r, s3_c_r, s3_d_r;
  logic [9:0] s3_raw0_r, s3_raw1_r, s3_raw2_r, s3_raw3_r;
  logic       s3_mode_r, s3_ok_r;
  key_t       key_r;

  logic [10:0] det_sum;

  assign det_sum = {1'b0, s1_ad_r} + DET_BIAS - {1'b0, s1_bc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r  <= 5'd1;
      key_b_r  <= 5'd0;
      key_c_r  <= 5'd0;
      key_d_r  <= 5'd1;
      mode_r   <= 1'b0;
      settle_r <= KEY_LAT;
    end else begin
      if (cfg_fire) begin
        settle_r <= KEY_LAT;
        unique case (cfg_index)
          CFG_KEY_A: key_a_r <= cfg_data;
          CFG_KEY_B: key_b_r <= cfg_data;
          CFG_KEY_C: key_c_r <= cfg_data;
          CFG_KEY_D: key_d_r <= cfg_data;
          CFG_MODE:  mode_r  <= cfg_data[0];
          default: ;
        endcase
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r    <= red26(key_a_r);
    s1_b_r    <= red26(key_b_r);
    s1_c_r    <= red26(key_c_r);
    s1_d_r    <= red26(key_d_r);
    s1_ad_r   <= red26(key_a_r) * red26(key_d_r);
    s1_bc_r   <= red26(key_b_r) * red26(key_c_r);
    s1_mode_r <= mode_r;

    s2_a_r    <= s1_a_r;
    s2_b_r    <= s1_b_r;
    s2_c_r    <= s1_c_r;
    s2_d_r    <= s1_d_r;
    s2_r_r    <= recip26(mod26(det_sum));
    s2_mode_r <= s1_mode_r;

    s3_a_r    <= s2_a_r;
    s3_b_r    <= s2_b_r;
    s3_c_r    <= s2_c_r;
    s3_d_r    <= s2_d_r;
    s3_raw0_r <= s2_d_r * s2_r_r;
    s3_raw1_r <= (ALPHA_N - s2_b_r) * s2_r_r;
    s3_raw2_r <= (ALPHA_N - s2_c_r) * s2_r_r;
    s3_raw3_r <= s2_a_r * s2_r_r;
    s3_ok_r   <= (s2_r_r != 5'd0);
    s3_mode_r <= s2_mode_r;

    if (s3_mode_r) begin
      key_r.m0 <= mod26({1'b0, s3_raw0_r});
      key_r.m1 <= mod26({1'b0, s3_raw1_r});
      key_r.m2 <= mod26({1'b0, s3_raw2_r});
      key_r.m3 <= mod26({1'b0, s3_raw3_r});
      key_r.ok <= s3_ok_r;
    end else begin
      key_r.m0 <= s3_a_r;
      key_r.m1 <= s3_b_r;
      key_r.m2 <= s3_c_r;
      key_r.m3 <= s3_d_r;
      key_r.ok <= 1'b1;
    end
  end

  assign key       = key_r;
  assign key_ready = (settle_r == 3'd0);

endmodule

FILE: sv/hc_pair_unit.sv
// letter filter, pair holding state and the key products into the work register
module hc_pair_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hc_pkg::hc_in_t     in_data,
  input  hc_pkg::key_t       key,
  input  logic               key_ready,
  input  logic               b_free,
  output logic               a_valid,
  output hc_pkg::pair_item_t a_item
);
  import hc_pkg::*;

  logic       holding_r, holding_nxt;
  logic [4:0] held_r, held_nxt;
  logic       a_valid_r, a_valid_nxt;
  pair_item_t a_item_r, a_item_nxt;

  logic       in_fire, a_free;
  logic       is_lc, is_uc, is_letter;
  logic [7:0] v_full;
  logic [4:0] v, held_upd, p1, p2;
  logic       hold_upd, pair_now, produce;
  logic [9:0] pr0, pr1, pr2, pr3;

  assign a_free   = !a_valid_r || b_free;
  assign in_ready = a_free && key_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_lc     = (in_data.char_code >= CHAR_LC_A) && (in_data.char_code <= CHAR_LC_Z);
  assign is_uc     = (in_data.char_code >= CHAR_UC_A) && (in_data.char_code <= CHAR_UC_Z);
  assign is_letter = is_lc || is_uc;
  assign v_full    = in_data.char_code - (is_lc ? CHAR_LC_A : CHAR_UC_A);
  assign v         = v_full[4:0];

  always_comb begin
    pair_now = is_letter && holding_r;
    hold_upd = holding_r;
    held_upd = held_r;
    if (is_letter) begin
      hold_upd = !holding_r;
      held_upd = holding_r ? 5'd0 : v;
    end
    p1 = held_r;
    p2 = v;
    // lone letter at end of text gets the pad letter
    if (!pair_now) begin
      p1 = held_upd;
      p2 = PAD_LETTER;
    end
    pr0 = p1 * key.m0;
    pr1 = p2 * key.m1;
    pr2 = p1 * key.m2;
    pr3 = p2 * key.m3;

    holding_nxt = holding_r;
    held_nxt    = held_r;
    a_valid_nxt = a_valid_r && !b_free;
    a_item_nxt  = a_item_r;
    produce     = 1'b0;

    if (in_fire) begin
      a_item_nxt.text_end = in_data.text_end;
      a_item_nxt.sum1     = {1'b0, pr0} + {1'b0, pr1};
      a_item_nxt.sum2     = {1'b0, pr2} + {1'b0, pr3};
      if (!key.ok) begin
        a_item_nxt.kind = KIND_ERR;
        produce         = in_data.text_end;
      end else begin
        holding_nxt = hold_upd;
        held_nxt    = held_upd;
        if (pair_now || (in_data.text_end && hold_upd)) begin
          a_item_nxt.kind = KIND_PAIR;
          produce         = 1'b1;
        end else begin
          a_item_nxt.kind = KIND_END;
          produce         = in_data.text_end;
        end
      end
      if (in_data.text_end) begin
        holding_nxt = 1'b0;
        held_nxt    = 5'd0;
      end
      if (produce) begin
        a_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r <= 1'b0;
      held_r    <= 5'd0;
      a_valid_r <= 1'b0;
    end else begin
      holding_r <= holding_nxt;
      held_r    <= held_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
  end

  assign a_valid = a_valid_r;
  assign a_item  = a_item_r;

endmodule

FILE: sv/hc_out_unit.sv
// mod 26 reduction into the result register and the one- or two-beat sequencer
module hc_out_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               a_valid,
  input  hc_pkg::pair_item_t a_item,
  output logic               b_free,
  output logic               out_valid,
  input  logic               out_ready,
  output hc_pkg::hc_out_t    out_data
);
  import hc_pkg::*;

  logic       b_valid_r;
  logic       beat_r;
  kind_t      kind_r;
  logic [4:0] l1_r, l2_r;
  logic       end_r;

  logic       b_done, load;
  hc_out_t    res;

  assign b_done = b_valid_r && out_ready && (beat_r || (kind_r != KIND_PAIR));
  assign b_free = !b_valid_r || b_done;
  assign load   = a_valid && b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      beat_r    <= 1'b0;
    end else if (load) begin
      b_valid_r <= 1'b1;
      beat_r    <= 1'b0;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
      beat_r    <= 1'b0;
    end else if (b_valid_r && out_ready) begin
      beat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= a_item.kind;
      l1_r   <= mod26(a_item.sum1);
      l2_r   <= mod26(a_item.sum2);
      end_r  <= a_item.text_end;
    end
  end

  always_comb begin
    res = '0;
    unique case (kind_r)
      KIND_PAIR: begin
        res.out_letter  = OUT_BASE + {2'b00, (beat_r ? l2_r : l1_r)};
        res.has_letter  = 1'b1;
        res.last_of_run = beat_r;
        res.end_marker  = beat_r && end_r;
      end
      KIND_ERR: begin
        res.last_of_run = 1'b1;
        res.end_marker  = 1'b1;
        res.key_error   = 1'b1;
      end
      default: begin
        res.last_of_run = 1'b1;
        res.end_marker  = 1'b1;
      end
    endcase
  end

  assign out_valid = b_valid_r;
  assign out_data  = res;

endmodule

FILE: sv/hill_cipher_2x2_mod26_unit.sv
// top level of the 2x2 mod 26 hill cipher unit
//
//  port group  dir  beat contents
//  in_*        in   one text byte and its end-of-text flag
//  out_*       out  at most one result letter with run, end and key error flags
//  cfg_*       in   register index 0..4 and 5-bit write data
//
// a byte is captured in the work register, then reduced into the result register
// a letter pair leaves as two beats; the single output register takes the next
// item only as the second beat leaves, so it is the limit
// after reset and after every register write in_ready stays low while the key
// pipeline recomputes the active matrix
// in_ready also drops while the work register waits on a stalled output
module hill_cipher_2x2_mod26_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hc_pkg::hc_in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hc_pkg::hc_out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [4:0]       cfg_data
);
  import hc_pkg::*;

  key_t       key;
  logic       key_ready;
  logic       a_valid;
  pair_item_t a_item;
  logic       b_free;

  assign cfg_ready = 1'b1;

  hc_key_unit u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .key_ready (key_ready)
  );

  hc_pair_unit u_pair (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .key       (key),
    .key_ready (key_ready),
    .b_free    (b_free),
    .a_valid   (a_valid),
    .a_item    (a_item)
  );

  hc_out_unit u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_item    (a_item),
    .b_free    (b_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a letter beat always carries an upper-case letter
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_letter |->
      (out_data.out_letter >= OUT_BASE) && (out_data.out_letter <= 7'd90))
    else $error("letter beat outside A..Z");

  // key error only on a bare end-of-text beat
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_error |->
      out_data.end_marker && out_data.last_of_run && !out_data.has_letter)
    else $error("key error beat malformed");

  // the first beat of a pair is followed by its second
  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |=> out_valid && out_data.has_letter)
    else $error("second letter of pair missing");

  // no byte is taken while the key matrix is being recomputed
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during key update");
`endif

endmodule

FILE: sim/tb_hill_cipher_2x2_mod26_unit.sv
// testbench for the 2x2 mod 26 hill cipher unit: directed and random text against a predictor
`timescale 1ns / 100ps

module tb_hill_cipher_2x2_mod26_unit;
  import hc_pkg::*;

  localparam int ALPHABET     = 26;
  localparam int DRAIN_GUARD  = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 50;
  localparam int TAIL_ITEMS   = 40;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  hc_in_t  in_data;
  logic    out_valid;
  logic    out_ready;
  hc_out_t out_data;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [2:0] cfg_index;
  logic [4:0] cfg_data;

  // predictor copy of the registers and the pairing state
  logic [4:0] ka = 5'd1, kb = 5'd0, kc = 5'd0, kd = 5'd1;
  logic       dec_on = 1'b0;
  int         pend_letter = 0;
  bit         pend_valid = 1'b0;

  hc_out_t cipher_beats_q[$];
  int      failures = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  int      gap_odds = 4;

  hill_cipher_2x2_mod26_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic hc_out_t result_beat(input int letter, input bit has, input bit last,
                                          input bit endm, input bit err);
    hc_out_t r;
    r.out_letter  = letter[6:0];
    r.has_letter  = has;
    r.last_of_run = last;
    r.end_marker  = endm;
    r.key_error   = err;
    return r;
  endfunction

  // append one predicted beat at the tail of the queue
  function automatic void expect_beat(input hc_out_t r);
    cipher_beats_q = {cipher_beats_q, r};
  endfunction

  // active matrix; decrypt uses reciprocal of det times the adjugate
  function automatic bit cipher_matrix(output int k0, output int k1, output int k2,
                                       output int k3);
    int a, b, c, d, det, r;
    a = ka % ALPHABET;
    b = kb % ALPHABET;
    c = kc % ALPHABET;
    d = kd % ALPHABET;
    k0 = a; k1 = b; k2 = c; k3 = d;
    if (!dec_on) return 1'b1;
    det = (a * d - b * c) % ALPHABET;
    if (det < 0) det += ALPHABET;
    r = 0;
    for (int i = 1; i < ALPHABET; i++) begin
      if ((det * i) % ALPHABET == 1) r = i;
    end
    if (r == 0) return 1'b0;
    k0 = (d * r) % ALPHABET;
    k1 = ((ALPHABET - b) * r) % ALPHABET;
    k2 = ((ALPHABET - c) * r) % ALPHABET;
    k3 = (a * r) % ALPHABET;
    return 1'b1;
  endfunction

  function automatic void encipher_byte(input hc_in_t b);
    int k0, k1, k2, k3, v, p1, p2;
    bit ok, letter, pair;
    ok = cipher_matrix(k0, k1, k2, k3);
    letter = 1'b0;
    v = 0;
    p1 = 0;
    p2 = 0;
    pair = 1'b0;
    if (b.char_code >= CHAR_LC_A && b.char_code <= CHAR_LC_Z) begin
      letter = 1'b1;
      v = b.char_code - CHAR_LC_A;
    end else if (b.char_code >= CHAR_UC_A && b.char_code <= CHAR_UC_Z) begin
      letter = 1'b1;
      v = b.char_code - CHAR_UC_A;
    end
    // unusable key: letters vanish, only the end of text reports
    if (!ok) begin
      if (b.text_end) begin
        pend_valid = 1'b0;
        pend_letter = 0;
        expect_beat(result_beat(0, 1'b0, 1'b1, 1'b1, 1'b1));
      end
      return;
    end
    if (letter) begin
      if (pend_valid) begin
        p1 = pend_letter;
        p2 = v;
        pair = 1'b1;
        pend_valid = 1'b0;
        pend_letter = 0;
      end else begin
        pend_letter = v;
        pend_valid = 1'b1;
      end
    end
    if (b.text_end && !pair && pend_valid) begin
      p1 = pend_letter;
      p2 = PAD_LETTER;
      pair = 1'b1;
    end
    if (b.text_end) begin
      pend_valid = 1'b0;
      pend_letter = 0;
    end
    if (pair) begin
      expect_beat(result_beat((p1 * k0 + p2 * k1) % ALPHABET + OUT_BASE,
                              1'b1, 1'b0, 1'b0, 1'b0));
      expect_beat(result_beat((p1 * k2 + p2 * k3) % ALPHABET + OUT_BASE,
                              1'b1, 1'b1, b.text_end, 1'b0));
    end else if (b.text_end) begin
      expect_beat(result_beat(0, 1'b0, 1'b1, 1'b1, 1'b0));
    end
  endfunction

  // result side: compare every accepted beat with the oldest prediction
  always @(posedge clk) begin
    hc_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (cipher_beats_q.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        failures++;
      end else begin
        want = cipher_beats_q.pop_front();
        if (out_data.out_letter !== want.out_letter) begin
          $error("out_letter expected %0d got %0d", want.out_letter, out_data.out_letter);
          failures++;
        end
        if (out_data.has_letter !== want.has_letter) begin
          $error("has_letter expected %0d got %0d", want.has_letter, out_data.has_letter);
          failures++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0d got %0d", want.last_of_run, out_data.last_of_run);
          failures++;
        end
        if (out_data.end_marker !== want.end_marker) begin
          $error("end_marker expected %0d got %0d", want.end_marker, out_data.end_marker);
          failures++;
        end
        if (out_data.key_error !== want.key_error) begin
          $error("key_error expected %0d got %0d", want.key_error, out_data.key_error);
          failures++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** hill_cipher_2x2_mod26_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input bit fin);
    hc_in_t beat;
    beat.char_code = ch;
    beat.text_end  = fin;
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    encipher_byte(beat);
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // wait for every expected beat, then let bytes with no result finish inside
  task automatic settle();
    in_valid <= 1'b0;
    while (cipher_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic load_key(input logic [4:0] a, input logic [4:0] b, input logic [4:0] c,
                          input logic [4:0] d, input logic [4:0] mode_word);
    cfg_idx_t   regs [5];
    logic [4:0] vals [5];
    regs = '{CFG_KEY_A, CFG_KEY_B, CFG_KEY_C, CFG_KEY_D, CFG_MODE};
    vals = '{a, b, c, d, mode_word};
    settle();
    foreach (regs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_KEY_A: ka = vals[i];
        CFG_KEY_B: kb = vals[i];
        CFG_KEY_C: kc = vals[i];
        CFG_KEY_D: kd = vals[i];
        CFG_MODE:  dec_on = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] rand_key_entry();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd25;
      2: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // mostly letters of both cases, some punctuation and raw bytes
  function automatic logic [7:0] rand_text_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return CHAR_LC_A + 8'($urandom_range(0, 25));
    if (r < 14) return CHAR_UC_A + 8'($urandom_range(0, 25));
    if (r < 17) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 64));
  endfunction

  task automatic test_reset_key();
    // identity key after reset: plain text comes back upper case, lone letter padded
    send_text("H i", 1'b0);
    send_text("z", 1'b1);
    settle();
  endtask

  task automatic test_byte_classes();
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 5'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'd64, 1'b0);
    send_byte(8'd65, 1'b0);
    send_byte(8'd91, 1'b0);
    send_byte(8'd96, 1'b0);
    send_byte(8'd90, 1'b0);
    send_byte(8'd122, 1'b0);
    send_byte(8'd123, 1'b0);
    send_byte(8'd225, 1'b0);
    send_byte(8'd97, 1'b0);
    // end on a non-letter with no letter held: a bare end beat
    send_byte(8'd46, 1'b1);
    // end with nothing held
    send_byte(8'd32, 1'b1);
    send_text("ab", 1'b1);
    settle();
  endtask

  task automatic test_key_extremes();
    load_key(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_text("qz", 1'b1);
    load_key(5'd31, 5'd31, 5'd31, 5'd31, 5'd0);
    send_text("yZ", 1'b1);
    load_key(5'd25, 5'd25, 5'd25, 5'd25, 5'd0);
    send_text("ma", 1'b1);
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 5'd1);
    send_text("helps", 1'b1);
    // entries above 25 reduce to the same invertible key
    load_key(5'd29, 5'd3, 5'd28, 5'd31, 5'd1);
    send_text("ZKDQ", 1'b1);
    // even determinant: letters dropped, error on end
    load_key(5'd2, 5'd4, 5'd6, 5'd8, 5'd1);
    send_text("abc", 1'b1);
    // determinant 13
    load_key(5'd13, 5'd0, 5'd0, 5'd1, 5'd1);
    send_text("de!", 1'b1);
    settle();
  endtask

  task automatic test_midtext_change();
    load_key(5'd7, 5'd8, 5'd11, 5'd11, 5'd0);
    send_text("q", 1'b0);
    // unusable key leaves the held letter alone
    load_key(5'd2, 5'd4, 5'd6, 5'd8, 5'd1);
    send_text("ab", 1'b0);
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 5'd0);
    send_text("r", 1'b0);
    send_text("m", 1'b0);
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 5'd1);
    send_text("n", 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    load_key(5'd5, 5'd17, 5'd4, 5'd15, 5'd0);
    gap_odds = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_byte(CHAR_LC_A + 8'($urandom_range(0, 25)), 1'b0);
    send_byte(8'd33, 1'b1);
    settle();
  endtask

  task automatic test_random_text();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_key(rand_key_entry(), rand_key_entry(), rand_key_entry(), rand_key_entry(),
               5'($urandom_range(0, 31)));
      gap_odds = (ph % 3 == 0) ? 0 : 4;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_byte(rand_text_byte(), $urandom_range(0, 11) == 0 || i == PHASE_ITEMS - 1);
    end
    gap_odds = 4;
    settle();
  endtask

  task automatic test_tail();
    quiet = 1'b1;
    load_key(5'd9, 5'd4, 5'd5, 5'd7, 5'd1);
    for (int i = 0; i < TAIL_ITEMS; i++)
      send_byte(rand_text_byte(), $urandom_range(0, 9) == 0 || i == TAIL_ITEMS - 1);
    settle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_key();
    test_byte_classes();
    test_key_extremes();
    test_midtext_change();
    test_backpressure();
    test_random_text();
    test_tail();
    settle();
    if (failures == 0) begin
      $display("** hill_cipher_2x2_mod26_unit: PASSED **");
    end else begin
      $display("** hill_cipher_2x2_mod26_unit: FAILED **");
    end
    $finish;
  end

endmodule
